@@ sv/atc_pkg.sv @@
// ----------------------------------------------------------------------------
// atc_pkg
// Shared operation codes for the affine transform accumulator.
// ----------------------------------------------------------------------------
package atc_pkg;

  // Width of the operation code carried in tuser.
  localparam int unsigned OpWidth = 2;

  // Operation codes. The fourth code is unused and leaves the transform as it is.
  typedef enum logic [OpWidth-1:0] {
    OP_IDENTITY  = 2'd0,
    OP_COMPOSE   = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_e;

endpackage

@@ sv/atc_datapath.sv @@
// ----------------------------------------------------------------------------
// atc_datapath
// Next value of the stored transform for one word: identity load, compose
// with an incoming transform, or translation of the offsets; an unused code keeps it.
// ----------------------------------------------------------------------------
module atc_datapath import atc_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 8,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  op_e                            op_i,
  input  logic signed [ENTRY_WIDTH-1:0]  acc_xx_i,
  input  logic signed [ENTRY_WIDTH-1:0]  acc_xy_i,
  input  logic signed [ENTRY_WIDTH-1:0]  acc_yx_i,
  input  logic signed [ENTRY_WIDTH-1:0]  acc_yy_i,
  input  logic signed [ENTRY_WIDTH-1:0]  acc_off_x_i,
  input  logic signed [ENTRY_WIDTH-1:0]  acc_off_y_i,
  input  logic signed [ENTRY_WIDTH-1:0]  in_xx_i,
  input  logic signed [ENTRY_WIDTH-1:0]  in_xy_i,
  input  logic signed [ENTRY_WIDTH-1:0]  in_yx_i,
  input  logic signed [ENTRY_WIDTH-1:0]  in_yy_i,
  input  logic signed [ENTRY_WIDTH-1:0]  in_off_x_i,
  input  logic signed [ENTRY_WIDTH-1:0]  in_off_y_i,
  output logic signed [ENTRY_WIDTH-1:0]  nxt_xx_o,
  output logic signed [ENTRY_WIDTH-1:0]  nxt_xy_o,
  output logic signed [ENTRY_WIDTH-1:0]  nxt_yx_o,
  output logic signed [ENTRY_WIDTH-1:0]  nxt_yy_o,
  output logic signed [ENTRY_WIDTH-1:0]  nxt_off_x_o,
  output logic signed [ENTRY_WIDTH-1:0]  nxt_off_y_o
);

  localparam int unsigned ProdWidth = 2 * ENTRY_WIDTH;
  // Only the bits up to the top of the shifted window matter, so sums wrap here.
  localparam int unsigned SumWidth  = ENTRY_WIDTH + FRAC_BITS;
  localparam logic [ENTRY_WIDTH-1:0] One =
    {{(ENTRY_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  // Sum of two signed products, shifted right by the fraction bits and
  // wrapped to the entry width.
  function automatic logic [ENTRY_WIDTH-1:0] dot_shift(
    input logic signed [ENTRY_WIDTH-1:0] a,
    input logic signed [ENTRY_WIDTH-1:0] b,
    input logic signed [ENTRY_WIDTH-1:0] c,
    input logic signed [ENTRY_WIDTH-1:0] d
  );
    logic signed [ProdWidth-1:0] p0;
    logic signed [ProdWidth-1:0] p1;
    logic        [SumWidth-1:0]  s;
    p0 = a * b;
    p1 = c * d;
    s  = p0[SumWidth-1:0] + p1[SumWidth-1:0];
    return s[SumWidth-1:FRAC_BITS];
  endfunction

  // Compose terms: twelve products, paired and shifted.
  logic [ENTRY_WIDTH-1:0] cmp_xx, cmp_xy, cmp_yx, cmp_yy, cmp_ox, cmp_oy;

  assign cmp_xx = dot_shift(acc_xx_i, in_xx_i, acc_xy_i, in_yx_i);
  assign cmp_xy = dot_shift(acc_xx_i, in_xy_i, acc_xy_i, in_yy_i);
  assign cmp_yx = dot_shift(acc_yx_i, in_xx_i, acc_yy_i, in_yx_i);
  assign cmp_yy = dot_shift(acc_yx_i, in_xy_i, acc_yy_i, in_yy_i);
  assign cmp_ox = dot_shift(acc_off_x_i, in_xx_i, acc_off_y_i, in_yx_i);
  assign cmp_oy = dot_shift(acc_off_x_i, in_xy_i, acc_off_y_i, in_yy_i);

  // Select the new transform by operation.
  always_comb begin
    nxt_xx_o    = acc_xx_i;
    nxt_xy_o    = acc_xy_i;
    nxt_yx_o    = acc_yx_i;
    nxt_yy_o    = acc_yy_i;
    nxt_off_x_o = acc_off_x_i;
    nxt_off_y_o = acc_off_y_i;
    unique case (op_i)
      OP_IDENTITY: begin
        nxt_xx_o    = One;
        nxt_xy_o    = '0;
        nxt_yx_o    = '0;
        nxt_yy_o    = One;
        nxt_off_x_o = '0;
        nxt_off_y_o = '0;
      end
      OP_COMPOSE: begin
        nxt_xx_o    = cmp_xx;
        nxt_xy_o    = cmp_xy;
        nxt_yx_o    = cmp_yx;
        nxt_yy_o    = cmp_yy;
        nxt_off_x_o = cmp_ox + in_off_x_i;
        nxt_off_y_o = cmp_oy + in_off_y_i;
      end
      OP_TRANSLATE: begin
        nxt_off_x_o = acc_off_x_i + in_off_x_i;
        nxt_off_y_o = acc_off_y_i + in_off_y_i;
      end
      default: begin
        // Unused code: the transform stays as it is.
      end
    endcase
  end

endmodule

@@ sv/affine_transform_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// affine_transform_accumulator_core
// Keeps a 2x3 fixed-point affine transform and updates it once per word.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output is ready and
// returns one result word for each. A word is first captured in an input
// register; once the result register is free or drained, the full update
// (twelve entry-wide multipliers, pairwise sums and the offset add) runs in
// one pass and is written into the transform registers, which also drive the
// result word. That loop through the multipliers back into the transform
// registers is what sets the rate of one word per cycle; a stalled output
// holds the pipeline, and a new word is still taken while the input register
// is empty.
module affine_transform_accumulator_core import atc_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 8,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Fields from bit 0: in_xx, in_xy, in_yx, in_yy, in_off_x, in_off_y.
  input  logic [(6*ENTRY_WIDTH+7)/8*8-1:0] s_axis_tdata_i,
  // Fields from bit 0: operation.
  input  logic [OpWidth-1:0]            s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // Fields from bit 0: out_xx, out_xy, out_yx, out_yy, out_off_x, out_off_y.
  output logic [(6*ENTRY_WIDTH+7)/8*8-1:0] m_axis_tdata_o
);

  localparam int unsigned W        = ENTRY_WIDTH;
  localparam int unsigned DataBits = 6 * ENTRY_WIDTH;
  localparam int unsigned PadBits  = (DataBits + 7) / 8 * 8 - DataBits;
  localparam int unsigned OutBits  = DataBits + PadBits;
  localparam logic [ENTRY_WIDTH-1:0] One =
    {{(ENTRY_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  // Input register.
  logic                  s1_valid_q;
  op_e                   s1_op_q;
  logic signed [W-1:0]   s1_xx_q, s1_xy_q, s1_yx_q, s1_yy_q, s1_ox_q, s1_oy_q;

  // Stored transform; it also forms the result word.
  logic signed [W-1:0]   acc_xx_q, acc_xy_q, acc_yx_q, acc_yy_q, acc_ox_q, acc_oy_q;
  logic signed [W-1:0]   acc_xx_d, acc_xy_d, acc_yx_d, acc_yy_d, acc_ox_d, acc_oy_d;
  logic                  out_valid_q;

  logic s_fire;
  logic s1_adv;

  // The input register moves on when the result register is free or drained.
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_op_q <= op_e'(s_axis_tuser_i);
      s1_xx_q <= s_axis_tdata_i[0*W +: W];
      s1_xy_q <= s_axis_tdata_i[1*W +: W];
      s1_yx_q <= s_axis_tdata_i[2*W +: W];
      s1_yy_q <= s_axis_tdata_i[3*W +: W];
      s1_ox_q <= s_axis_tdata_i[4*W +: W];
      s1_oy_q <= s_axis_tdata_i[5*W +: W];
    end
  end

  // Update of the transform for the word in the input register.
  atc_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_datapath (
    .op_i       (s1_op_q),
    .acc_xx_i   (acc_xx_q),
    .acc_xy_i   (acc_xy_q),
    .acc_yx_i   (acc_yx_q),
    .acc_yy_i   (acc_yy_q),
    .acc_off_x_i(acc_ox_q),
    .acc_off_y_i(acc_oy_q),
    .in_xx_i    (s1_xx_q),
    .in_xy_i    (s1_xy_q),
    .in_yx_i    (s1_yx_q),
    .in_yy_i    (s1_yy_q),
    .in_off_x_i (s1_ox_q),
    .in_off_y_i (s1_oy_q),
    .nxt_xx_o   (acc_xx_d),
    .nxt_xy_o   (acc_xy_d),
    .nxt_yx_o   (acc_yx_d),
    .nxt_yy_o   (acc_yy_d),
    .nxt_off_x_o(acc_ox_d),
    .nxt_off_y_o(acc_oy_d)
  );

  // Transform registers, identity after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_xx_q <= One;
      acc_xy_q <= '0;
      acc_yx_q <= '0;
      acc_yy_q <= One;
      acc_ox_q <= '0;
      acc_oy_q <= '0;
    end else if (s1_adv) begin
      acc_xx_q <= acc_xx_d;
      acc_xy_q <= acc_xy_d;
      acc_yx_q <= acc_yx_d;
      acc_yy_q <= acc_yy_d;
      acc_ox_q <= acc_ox_d;
      acc_oy_q <= acc_oy_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // The size cast fills the pad bits above the last field with zeros.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutBits'({acc_oy_q, acc_ox_q,
                                     acc_yy_q, acc_yx_q, acc_xy_q, acc_xx_q});

`ifndef SYNTH
  // A full input register facing a stalled result takes no new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while pipeline is blocked");

  // Every word that leaves the input register shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> m_axis_tvalid_o)
    else $error("update without a result");

  // An identity load leaves the identity in the transform.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_op_q == OP_IDENTITY |=>
      acc_xx_q == One && acc_yy_q == One && acc_xy_q == '0 && acc_ox_q == '0)
    else $error("identity load wrong");

  // A translation does not touch the linear part.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_op_q == OP_TRANSLATE |=> $stable(acc_xx_q) && $stable(acc_yx_q))
    else $error("translation changed the linear part");

  // Without an update the transform holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(acc_ox_q) && $stable(acc_xy_q))
    else $error("transform changed without an update");
`endif

endmodule
